// ===== src/plae_pkg.sv =====
`timescale 1ns / 1ps
// plae_pkg: op codes, FSM state type and fixed constants for the tone table engine.
// No dependencies.
package plae_pkg;

  typedef logic [2:0] op_code_t;

  localparam op_code_t OP_IDENT = 3'd0;
  localparam op_code_t OP_ADD   = 3'd1;
  localparam op_code_t OP_DIM   = 3'd2;
  localparam op_code_t OP_CUP   = 3'd3;
  localparam op_code_t OP_CDN   = 3'd4;
  localparam op_code_t OP_INV   = 3'd5;
  localparam op_code_t OP_PIX   = 3'd6;

  localparam int PIX_MAX  = 255;
  localparam int CTR_CAP  = 127;
  localparam int DVS_W    = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD,
    ST_EVAL,
    ST_DIVGO,
    ST_DIV
  } state_t;

endpackage

// ===== src/plae_ram.sv =====
`timescale 1ns / 1ps
// plae_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module plae_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/plae_div.sv =====
`timescale 1ns / 1ps
// plae_div: unsigned restoring divider, one quotient bit per cycle, 8-bit divisor.
// Depends on plae_pkg.
module plae_div #(
  parameter int DIV_W = 28
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DIV_W-1:0]            dividend,
  input  logic [plae_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [DIV_W-1:0]            quotient
);
  import plae_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIV_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/pixel_lut_adjust_engine_unit.sv =====
`timescale 1ns / 1ps
// pixel_lut_adjust_engine_unit: tone table kept in one RAM, swept entry by entry
// for table ops, read directly for pixel lookups. Uses plae_pkg, plae_ram, plae_div.
//
//  channel | ports                                   | dir | transfer when
//  in      | in_valid in_ready in_op in_param in_pixel_in | in  | in_valid & in_ready
//  out     | out_valid out_ready out_pixel_out       | out | out_valid & out_ready
//
// Pixel lookups: one per cycle while idle and unstalled; result passes the RAM read
// reg, then the output reg. Identity op: each entry gets its index. Add, subtract,
// invert: each entry is read, then written back. Raise contrast: bit-serial divider.
// Lower contrast: divides by 255, folding 8 bits a cycle.
// After reset the table is written to identity; in_ready stays low meanwhile.
// A stalled output holds a pending lookup; in_ready drops until the result register frees.
module pixel_lut_adjust_engine_unit #(
  parameter int LUT_ENTRIES = 256,
  parameter int ENTRY_WIDTH = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plae_pkg::op_code_t in_op,
  input  logic [7:0]         in_param,
  input  logic [7:0]         in_pixel_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_pixel_out
);
  import plae_pkg::*;

  localparam int AW    = $clog2(LUT_ENTRIES);
  localparam int DIV_W = ENTRY_WIDTH + 8;
  localparam int SW    = ENTRY_WIDTH + 10;
  localparam logic signed [SW-1:0] E_MAX =
    {{(SW-ENTRY_WIDTH+1){1'b0}}, {(ENTRY_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] E_MIN =
    {{(SW-ENTRY_WIDTH+1){1'b1}}, {(ENTRY_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] C255 = SW'(PIX_MAX);
  localparam logic [AW-1:0] LAST = AW'(LUT_ENTRIES - 1);

  function automatic logic [ENTRY_WIDTH-1:0] sat_f(input logic signed [SW-1:0] x);
    if (x > E_MAX) return E_MAX[ENTRY_WIDTH-1:0];
    if (x < E_MIN) return E_MIN[ENTRY_WIDTH-1:0];
    return x[ENTRY_WIDTH-1:0];
  endfunction

  state_t          state_r, state_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  op_code_t        op_r;
  logic [7:0]      param_r;
  logic [6:0]      q_r;
  logic [7:0]      d_r;
  logic [14:0]     cq_r;
  logic signed [SW-1:0] num_r;
  logic            look_vld_r, look_vld_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_pix_r;
  logic             fold_busy_r, fold_busy_nxt;
  logic             fold_done_r, fold_done_nxt;
  logic [DIV_W-1:0] fold_y_r, fold_y_nxt;
  logic [DIV_W-1:0] fold_q_r, fold_q_nxt;

  logic                   acc;
  logic                   out_free;
  logic                   last;
  logic                   is_ctr;
  logic [6:0]             q_in;
  logic [AW-1:0]          pix_addr;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata, ram_rdata;
  logic signed [ENTRY_WIDTH-1:0] ent_v;
  logic signed [SW-1:0]   rv, simple_res, x3, n3, n4, num_mag, qv;
  logic signed [ENTRY_WIDTH+8:0] prod;
  logic [7:0]             clamp_v;
  logic                   div_start, div_done;
  logic [DIV_W-1:0]       div_quo;
  logic [DVS_W-1:0]       div_dvs;
  logic                   fold_start;
  logic [DIV_W-1:0]       fold_hi, fold_lo;
  logic                   calc_done;
  logic [DIV_W-1:0]       calc_quo;

  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign last     = addr_r == LAST;
  assign is_ctr   = (op_r == OP_CUP) || (op_r == OP_CDN);
  assign q_in     = (in_param > 8'(CTR_CAP)) ? 7'(CTR_CAP) : in_param[6:0];
  assign pix_addr = (32'(in_pixel_in) >= LUT_ENTRIES) ? LAST : AW'(in_pixel_in);

  assign ent_v = ram_rdata;
  assign rv    = SW'(ent_v);

  always_comb begin
    case (op_r)
      OP_ADD:  simple_res = rv + SW'(param_r);
      OP_DIM:  simple_res = rv - SW'(param_r);
      default: simple_res = C255 - rv;
    endcase
  end

  assign x3   = rv - SW'(q_r);
  assign n3   = (x3 <<< 8) - x3;
  assign prod = ent_v * $signed({1'b0, d_r});
  assign n4   = SW'(prod) + SW'(cq_r);

  assign num_mag = num_r[SW-1] ? -num_r : num_r;
  assign div_dvs = d_r;

  // divide by 255: y = 256a + b gives y/255 = a + (a + b)/255
  assign fold_hi = DIV_W'(fold_y_r[DIV_W-1:8]);
  assign fold_lo = DIV_W'(fold_y_r[7:0]);

  always_comb begin
    fold_busy_nxt = fold_busy_r;
    fold_done_nxt = 1'b0;
    fold_y_nxt    = fold_y_r;
    fold_q_nxt    = fold_q_r;
    if (fold_start) begin
      fold_busy_nxt = 1'b1;
      fold_y_nxt    = num_mag[DIV_W-1:0];
      fold_q_nxt    = '0;
    end else if (fold_busy_r) begin
      if (fold_hi == '0) begin
        fold_busy_nxt = 1'b0;
        fold_done_nxt = 1'b1;
        if (fold_lo == DIV_W'(PIX_MAX)) begin
          fold_q_nxt = fold_q_r + DIV_W'(1);
        end
      end else begin
        fold_y_nxt = fold_hi + fold_lo;
        fold_q_nxt = fold_q_r + fold_hi;
      end
    end
  end

  assign calc_done = (op_r == OP_CUP) ? div_done : fold_done_r;
  assign calc_quo  = (op_r == OP_CUP) ? div_quo : fold_q_r;
  assign qv        = num_r[SW-1] ? -$signed(SW'(calc_quo)) : $signed(SW'(calc_quo));

  always_comb begin
    if (ent_v < 0) begin
      clamp_v = 8'd0;
    end else if (ent_v > $signed(ENTRY_WIDTH'(PIX_MAX))) begin
      clamp_v = 8'(PIX_MAX);
    end else begin
      clamp_v = ent_v[7:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_IDENT: state_nxt = ST_INIT;
            OP_ADD, OP_DIM, OP_CUP, OP_CDN, OP_INV: state_nxt = ST_RD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INIT:  state_nxt = last ? ST_IDLE : ST_INIT;
      ST_RD:    state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (is_ctr) begin
          state_nxt = ST_DIVGO;
        end else begin
          state_nxt = last ? ST_IDLE : ST_RD;
        end
      end
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (calc_done) begin
          state_nxt = last ? ST_IDLE : ST_RD;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = sat_f(simple_res);
    ram_re     = 1'b0;
    ram_raddr  = addr_r;
    div_start  = 1'b0;
    fold_start = 1'b0;
    addr_nxt   = addr_r;
    case (state_r)
      ST_IDLE: begin
        in_ready  = !look_vld_r || out_free;
        ram_re    = acc && (in_op == OP_PIX);
        ram_raddr = pix_addr;
        if (acc) begin
          addr_nxt = '0;
        end
      end
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = ENTRY_WIDTH'(addr_r);
        addr_nxt  = addr_r + AW'(1);
      end
      ST_RD: begin
        ram_re = 1'b1;
      end
      ST_EVAL: begin
        if (!is_ctr) begin
          ram_we   = 1'b1;
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_DIVGO: begin
        div_start  = op_r == OP_CUP;
        fold_start = op_r == OP_CDN;
      end
      ST_DIV: begin
        ram_wdata = sat_f(qv);
        if (calc_done) begin
          ram_we   = 1'b1;
          addr_nxt = addr_r + AW'(1);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    look_vld_nxt  = look_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (look_vld_r && out_free) begin
      out_valid_nxt = 1'b1;
      look_vld_nxt  = 1'b0;
    end
    if (acc && (in_op == OP_PIX)) begin
      look_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= '0;
      look_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fold_busy_r <= 1'b0;
      fold_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      look_vld_r  <= look_vld_nxt;
      out_valid_r <= out_valid_nxt;
      fold_busy_r <= fold_busy_nxt;
      fold_done_r <= fold_done_nxt;
    end
    fold_y_r <= fold_y_nxt;
    fold_q_r <= fold_q_nxt;
    if (acc) begin
      op_r    <= in_op;
      param_r <= in_param;
      q_r     <= q_in;
      d_r     <= 8'(PIX_MAX) - {q_in, 1'b0};
      cq_r    <= ({q_in, 8'd0}) - 15'(q_in);
    end
    if (state_r == ST_EVAL) begin
      num_r <= (op_r == OP_CUP) ? n3 : n4;
    end
    if (look_vld_r && out_free) begin
      out_pix_r <= clamp_v;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;

  plae_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (LUT_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plae_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_mag[DIV_W-1:0]),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !ram_we)
    else $error("table write while idle");

  a_look_hold: assert property (@(posedge clk) disable iff (!rst_n)
    look_vld_r && !out_free |=> look_vld_r && $stable(ram_rdata))
    else $error("pending lookup data lost");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside its wait state");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE && state_nxt == ST_IDLE |-> last)
    else $error("sweep ended before last entry");

endmodule
